// ----- rtl/mm_pkg.sv -----
package mm_pkg;

   localparam int unsigned WORD_BITS_DEF = 64;
   localparam int unsigned FIELD_BITS    = 64;

endpackage

// ----- rtl/modular_multiplier.sv -----
// channel  direction  ports                  contents
// req      in         req_tvalid/tready      tdata: mult_a, mult_b, modulus
// rsp      out        rsp_tvalid/tready      tdata: residue, tuser: zero_modulus
//
// WORD_BITS restoring steps form mult_a mod modulus, then 2*WORD_BITS steps double and
// conditionally add, one modular add per stage.
// a new request is taken every cycle while the pipeline moves.
// the whole pipeline holds when the last stage has a result and rsp_tready is low.
// synchronous reset clears only the valid bits.
module modular_multiplier #(
   parameter int unsigned WORD_BITS = mm_pkg::WORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [3*mm_pkg::FIELD_BITS-1:0]  req_tdata,   // mult_a, mult_b, modulus
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mm_pkg::FIELD_BITS-1:0]    rsp_tdata,   // residue
   output logic                             rsp_tuser    // zero_modulus
);
   import mm_pkg::*;

   localparam int unsigned STAGES = 3 * WORD_BITS;

   logic                 advance;
   logic [WORD_BITS-1:0] in_a;
   logic [WORD_BITS-1:0] in_b;
   logic [WORD_BITS-1:0] in_m;

   logic                 vld_ff  [STAGES];
   logic                 zero_ff [STAGES];
   logic [WORD_BITS-1:0] a_ff    [STAGES];
   logic [WORD_BITS-1:0] b_ff    [STAGES];
   logic [WORD_BITS-1:0] m_ff    [STAGES];
   logic [WORD_BITS-1:0] ar_ff   [STAGES];
   logic [WORD_BITS-1:0] x_ff    [STAGES];

   assign advance    = !vld_ff[STAGES-1] || rsp_tready;
   assign req_tready = advance;

   assign in_a = req_tdata[WORD_BITS-1:0];
   assign in_b = req_tdata[FIELD_BITS +: WORD_BITS];
   assign in_m = req_tdata[2*FIELD_BITS +: WORD_BITS];

   genvar s;
   generate
      for (s = 0; s < STAGES; s++) begin : g_stage
         logic                 vld_in;
         logic                 zero_in;
         logic [WORD_BITS-1:0] a_in;
         logic [WORD_BITS-1:0] b_in;
         logic [WORD_BITS-1:0] m_in;
         logic [WORD_BITS-1:0] ar_in;
         logic [WORD_BITS-1:0] x_in;
         logic [WORD_BITS-1:0] y_in;
         logic                 carry_in;

         if (s == 0) begin : g_first
            assign vld_in  = req_tvalid;
            assign zero_in = (in_m == '0);
            assign a_in    = in_a;
            assign b_in    = in_b;
            assign m_in    = in_m;
            assign ar_in   = '0;
            assign x_in    = '0;
         end else begin : g_next
            assign vld_in  = vld_ff[s-1];
            assign zero_in = zero_ff[s-1];
            assign a_in    = a_ff[s-1];
            assign b_in    = b_ff[s-1];
            assign m_in    = m_ff[s-1];
            assign ar_in   = (s == WORD_BITS) ? x_ff[s-1] : ar_ff[s-1];
            assign x_in    = (s == WORD_BITS) ? '0 : x_ff[s-1];
         end

         if (s < WORD_BITS) begin : g_reduce
            // remainder walk over mult_a, msb first
            assign y_in     = x_in;
            assign carry_in = a_in[WORD_BITS-1-s];
         end else if (((s - WORD_BITS) % 2) == 0) begin : g_double
            assign y_in     = x_in;
            assign carry_in = 1'b0;
         end else begin : g_add
            assign y_in     = b_in[WORD_BITS-1-((s - WORD_BITS) / 2)] ? ar_in : '0;
            assign carry_in = 1'b0;
         end

         mm_step #(
            .WIDTH(WORD_BITS)
         ) u_step (
            .clock   (clock),
            .enable  (advance),
            .x_in    (x_in),
            .y_in    (y_in),
            .carry_in(carry_in),
            .mod_in  (m_in),
            .sum_ff  (x_ff[s])
         );

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else if (advance) begin
               vld_ff[s] <= vld_in;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               zero_ff[s] <= zero_in;
               a_ff[s]    <= a_in;
               b_ff[s]    <= b_in;
               m_ff[s]    <= m_in;
               ar_ff[s]   <= ar_in;
            end
         end
      end
   endgenerate

   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tuser  = zero_ff[STAGES-1];
   assign rsp_tdata  = zero_ff[STAGES-1] ? '0 : FIELD_BITS'(x_ff[STAGES-1]);

endmodule

// ----- rtl/mm_step.sv -----
module mm_step #(
   parameter int unsigned WIDTH = 64
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] x_in,
   input  logic [WIDTH-1:0] y_in,
   input  logic             carry_in,
   input  logic [WIDTH-1:0] mod_in,
   output logic [WIDTH-1:0] sum_ff
);

   logic [WIDTH:0]   total;
   logic [WIDTH:0]   reduced;
   logic [WIDTH-1:0] sum_in;

   // x + y + carry stays below 2m, so one conditional subtract brings it back below m
   always_comb begin
      total   = {1'b0, x_in} + {1'b0, y_in} + {{WIDTH{1'b0}}, carry_in};
      reduced = total - {1'b0, mod_in};
      if (total >= {1'b0, mod_in}) begin
         sum_in = reduced[WIDTH-1:0];
      end else begin
         sum_in = total[WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

   localparam int unsigned WB = mm_pkg::WORD_BITS_DEF;
   localparam int unsigned FB = mm_pkg::FIELD_BITS;
   localparam int unsigned PIPE_DEPTH = 3 * WB;
   localparam longint unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [FB-1:0] residue;
      logic          zero_modulus;
   } product_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [3*FB-1:0]      req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [FB-1:0]        rsp_tdata;
   logic                 rsp_tuser;

   product_type          expected_q[$];
   int unsigned          mismatch_count;
   longint unsigned      cycle_count;
   bit                   sender_bursty;
   bit                   receiver_bursty;
   int unsigned          hold_off_cycles;
   bit                   long_stall_req;
   bit                   long_stall_seen;

   modular_multiplier u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shift-and-add over the bits of b, each step a non-overflowing modular add
   function automatic product_type predict_product(logic [FB-1:0] a, logic [FB-1:0] b,
                                                   logic [FB-1:0] m);
      logic [FB:0]   mask;
      logic [FB-1:0] am;
      logic [FB-1:0] bm;
      logic [FB-1:0] mm;
      logic [FB:0]   acc;
      logic [FB:0]   ar;
      product_type   p;
      mask = (FB+1)'({WB{1'b1}});
      am = a & mask[FB-1:0];
      bm = b & mask[FB-1:0];
      mm = m & mask[FB-1:0];
      if (mm == '0) begin
         p.residue = '0;
         p.zero_modulus = 1'b1;
         return p;
      end
      ar = {1'b0, am % mm};
      acc = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         acc = acc + acc;
         if (acc >= {1'b0, mm}) acc = acc - {1'b0, mm};
         if (bm[i]) begin
            acc = acc + ar;
            if (acc >= {1'b0, mm}) acc = acc - {1'b0, mm};
         end
      end
      p.residue = acc[FB-1:0];
      p.zero_modulus = 1'b0;
      return p;
   endfunction

   task automatic report_mismatch(string what, logic [FB-1:0] got, logic [FB-1:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      mismatch_count++;
   endtask

   task automatic send_request(logic [FB-1:0] a, logic [FB-1:0] b, logic [FB-1:0] m);
      int unsigned gap;
      if (sender_bursty && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {m, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(predict_product(a, b, m));
   endtask

   task automatic idle_sender();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      idle_sender();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [FB-1:0] random_word();
      logic [FB-1:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: w = w >> $urandom_range(0, FB - 1);
         1: w = w | ({FB{1'b1}} << $urandom_range(0, FB - 1));
         2: w = FB'($urandom_range(0, 3));
         3: w = {FB{1'b1}} - FB'($urandom_range(0, 3));
         default: ;
      endcase
      return w;
   endfunction

   // result checker
   always @(posedge clock) begin
      product_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata, '0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata !== want.residue) report_mismatch("residue", rsp_tdata, want.residue);
            if (rsp_tuser !== want.zero_modulus)
               report_mismatch("zero_modulus", {{(FB-1){1'b0}}, rsp_tuser},
                               {{(FB-1){1'b0}}, want.zero_modulus});
         end
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         hold_off_cycles <= 0;
         long_stall_seen <= long_stall_req;
      end else if (long_stall_req != long_stall_seen) begin
         // long hold-off asked for by a test
         long_stall_seen <= long_stall_req;
         hold_off_cycles <= PIPE_DEPTH * 2 - 1;
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles != 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else if (receiver_bursty && $urandom_range(0, 5) == 0) begin
         hold_off_cycles <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic test_corners();
      logic [FB-1:0] ones;
      ones = '1;
      send_request(64'd0, 64'd0, 64'd0);
      send_request(ones, ones, 64'd0);
      send_request(ones, ones, ones);
      send_request(ones, ones, ones - 1);
      send_request(ones, 64'd1, ones);
      send_request(64'd0, ones, 64'd7);
      send_request(64'd5, 64'd7, 64'd1);
      send_request(ones, ones, 64'd2);
      send_request(64'h8000_0000_0000_0000, 64'd2, 64'h8000_0000_0000_0001);
      send_request(ones - 1, ones - 2, ones - 3);
      send_request(64'd12345, 64'd67890, 64'd1000000007);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hFFFF_FFFF_0000_0001);
      send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h7FFF_FFFF_FFFF_FFFF);
      send_request(64'd3, 64'd3, 64'd10);
      send_request(ones, ones, 64'h1_0000_0000);
      send_request(64'd1, 64'd1, ones);
      wait_for_drain();
   endtask

   task automatic test_random(int unsigned count);
      logic [FB-1:0] m;
      for (int unsigned i = 0; i < count; i++) begin
         m = ($urandom_range(0, 40) == 0) ? '0 : random_word();
         send_request(random_word(), random_word(), m);
      end
      wait_for_drain();
   endtask

   // receiver stalls long enough for the pipeline to fill and push back on requests
   task automatic test_backpressure();
      long_stall_req <= !long_stall_req;
      for (int unsigned i = 0; i < PIPE_DEPTH + 40; i++)
         send_request(random_word(), random_word(), random_word() | 64'd1);
      wait_for_drain();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      mismatch_count = 0;
      cycle_count = 0;
      long_stall_req = 1'b0;
      sender_bursty = 1'b0;
      receiver_bursty = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corners();
      sender_bursty = 1'b1;
      receiver_bursty = 1'b1;
      test_random(900);
      test_backpressure();
      sender_bursty = 1'b0;
      receiver_bursty = 1'b0;
      test_random(600);

      repeat (PIPE_DEPTH + 20) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
